FILE: src/lom_pkg.sv
// Package for the limit order matcher core: sizes, status codes and the
// controller-to-datapath command and status structs. No dependencies.
package lom_pkg;

  localparam int BOOK_SLOTS = 32;
  localparam int SLOT_W = $clog2(BOOK_SLOTS);
  localparam int SCAN_W = $clog2(BOOK_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_INVALID   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_CAPACITY  = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_t;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic fill;
    logic rest;
    logic cancel;
    logic emit_trade;
    logic emit_status;
    status_t emit_code;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic id_found;
    logic free_found;
    logic best_found;
    logic rem_zero;
    logic trades_full;
    logic count_max;
    logic is_cancel;
    logic is_invalid;
  } dp_sts_t;

endpackage

FILE: src/lom_datapath.sv
// Datapath of the limit order matcher: book slot registers, a serial scan
// over the slots, fill and rest logic, and the result registers. Uses lom_pkg.
module lom_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             start_beat,
  input  logic             mode_in,
  input  logic [31:0]      order_id_in,
  input  logic             side_in,
  input  logic [31:0]      price_in,
  input  logic [31:0]      quantity_in,
  input  lom_pkg::dp_cmd_t cmd,
  output lom_pkg::dp_sts_t sts,
  output logic             strobe,
  output logic             is_trade,
  output logic [31:0]      maker_id,
  output logic [31:0]      taker_id,
  output logic [31:0]      trade_price,
  output logic [31:0]      trade_quantity,
  output logic [63:0]      sequence_res,
  output logic [2:0]       status,
  output logic [31:0]      remaining,
  output logic             last
);
  import lom_pkg::*;

  logic [BOOK_SLOTS-1:0] used;
  logic [31:0] s_id [BOOK_SLOTS];
  logic        s_side [BOOK_SLOTS];
  logic [31:0] s_price [BOOK_SLOTS];
  logic [31:0] s_qty [BOOK_SLOTS];
  logic [63:0] s_arr [BOOK_SLOTS];

  logic        c_mode, c_side;
  logic [31:0] c_id, c_price, c_rem;
  logic [63:0] count;
  logic [SCAN_W-1:0] idx, trades;
  logic id_hit, free_hit, best_hit;
  logic [SLOT_W-1:0] id_slot, free_slot, best_slot;
  logic [31:0] best_price;
  logic [63:0] best_arr;
  logic [SLOT_W-1:0] cur;
  logic crosses, better;
  logic [31:0] traded;

  assign cur = idx[SLOT_W-1:0];
  assign crosses = used[cur] && (s_side[cur] != c_side) &&
                   (c_side ? (s_price[cur] >= c_price) : (s_price[cur] <= c_price));
  assign better = !best_hit ||
                  (c_side ? (s_price[cur] > best_price) : (s_price[cur] < best_price)) ||
                  (s_price[cur] == best_price && s_arr[cur] < best_arr);
  assign traded = (c_rem < s_qty[best_slot]) ? c_rem : s_qty[best_slot];

  assign sts.scan_done   = (idx == SCAN_W'(BOOK_SLOTS));
  assign sts.id_found    = id_hit;
  assign sts.free_found  = free_hit;
  assign sts.best_found  = best_hit;
  assign sts.rem_zero    = (c_rem == 32'd0);
  assign sts.trades_full = (trades == SCAN_W'(BOOK_SLOTS));
  assign sts.count_max   = (count == {64{1'b1}});
  assign sts.is_cancel   = c_mode;
  assign sts.is_invalid  = (c_price == 32'd0) || (c_rem == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      count <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_trade || cmd.emit_status;
      if (start_beat && !(count == {64{1'b1}}))
        count <= count + 64'd1;
      if (cmd.cancel)
        used[id_slot] <= 1'b0;
      if (cmd.fill && traded == s_qty[best_slot])
        used[best_slot] <= 1'b0;
      if (cmd.rest)
        used[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_beat) begin
      c_mode <= mode_in;
      c_id <= order_id_in;
      c_side <= side_in;
      c_price <= price_in;
      c_rem <= quantity_in;
      trades <= '0;
    end
    if (cmd.scan_start) begin
      idx <= '0;
      id_hit <= 1'b0;
      free_hit <= 1'b0;
      best_hit <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx <= idx + SCAN_W'(1);
      if (!id_hit && used[cur] && s_id[cur] == c_id) begin
        id_hit <= 1'b1;
        id_slot <= cur;
      end
      if (!free_hit && !used[cur]) begin
        free_hit <= 1'b1;
        free_slot <= cur;
      end
      if (crosses && better) begin
        best_hit <= 1'b1;
        best_slot <= cur;
        best_price <= s_price[cur];
        best_arr <= s_arr[cur];
      end
    end
    if (cmd.fill) begin
      s_qty[best_slot] <= s_qty[best_slot] - traded;
      c_rem <= c_rem - traded;
      trades <= trades + SCAN_W'(1);
    end
    if (cmd.rest) begin
      s_id[free_slot] <= c_id;
      s_side[free_slot] <= c_side;
      s_price[free_slot] <= c_price;
      s_qty[free_slot] <= c_rem;
      s_arr[free_slot] <= count;
    end
    if (cmd.emit_trade) begin
      is_trade <= 1'b1;
      maker_id <= s_id[best_slot];
      taker_id <= c_id;
      trade_price <= s_price[best_slot];
      trade_quantity <= traded;
      sequence_res <= count;
      status <= ST_ACCEPTED;
      remaining <= '0;
      last <= 1'b0;
    end
    if (cmd.emit_status) begin
      is_trade <= 1'b0;
      maker_id <= '0;
      taker_id <= '0;
      trade_price <= '0;
      trade_quantity <= '0;
      sequence_res <= count;
      status <= cmd.emit_code;
      remaining <= (cmd.emit_code == ST_ACCEPTED) ? c_rem : 32'd0;
      last <= 1'b1;
    end
  end

endmodule

FILE: src/lom_ctrl.sv
// Controller of the limit order matcher: sequences checks, scans, fills
// and the final status beat. Uses lom_pkg; drives lom_datapath.
module lom_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start_beat,
  input  logic             was_max,
  input  lom_pkg::dp_sts_t sts,
  output lom_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import lom_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FIRST = 6'b001000,
    S_FILL  = 6'b010000,
    S_END   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic ex, ex_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit_code = ST_ACCEPTED;
    state_next = state;
    ex_next = ex;
    case (state)
      S_IDLE: begin
        if (start_beat) begin
          ex_next = was_max;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ex) begin
          cmd.emit_status = 1'b1;
          cmd.emit_code = ST_EXHAUSTED;
          state_next = S_IDLE;
        end else if (!sts.is_cancel && sts.is_invalid) begin
          cmd.emit_status = 1'b1;
          cmd.emit_code = ST_INVALID;
          state_next = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (sts.is_cancel) begin
          cmd.emit_status = 1'b1;
          cmd.emit_code = sts.id_found ? ST_CANCELLED : ST_UNKNOWN;
          cmd.cancel = sts.id_found;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (sts.id_found) begin
          cmd.emit_status = 1'b1;
          cmd.emit_code = ST_DUPLICATE;
          state_next = S_IDLE;
        end else if (!sts.free_found && !sts.best_found) begin
          cmd.emit_status = 1'b1;
          cmd.emit_code = ST_CAPACITY;
          state_next = S_IDLE;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (sts.best_found && !sts.rem_zero && !sts.trades_full) begin
          cmd.fill = 1'b1;
          cmd.emit_trade = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_END;
        end else begin
          cmd.rest = !sts.rem_zero && sts.free_found;
          cmd.emit_status = 1'b1;
          cmd.emit_code = ST_ACCEPTED;
          state_next = S_IDLE;
        end
      end
      S_END: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_FILL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ex <= 1'b0;
    end else begin
      state <= state_next;
      ex <= ex_next;
    end
  end

endmodule

FILE: src/limit_order_matcher_core.sv
// Top level of the limit order matcher core: joins lom_ctrl and
// lom_datapath. Uses lom_pkg.
// A command is taken when start is high and busy is low. Each command that
// passes the checks scans all book slots serially, one slot per cycle, and a
// new order scans them again after every trade. Busy stays high until the
// final status beat is formed, so no new command is taken before the last
// is through. Results come out one beat per strobe, each in the cycle after
// it is formed, and cannot be stalled; the final status beat comes in the
// same cycle that busy falls and has last set. There is no clearing pass.
module limit_order_matcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  output logic        strobe,
  output logic        is_trade,
  output logic [31:0] maker_id,
  output logic [31:0] taker_id,
  output logic [31:0] trade_price,
  output logic [31:0] trade_quantity,
  output logic [63:0] sequence_res,
  output logic [2:0]  status,
  output logic [31:0] remaining,
  output logic        last
);
  import lom_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic start_beat;

  assign start_beat = start && !busy;

  lom_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start_beat(start_beat), .was_max(sts.count_max),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  lom_datapath u_dp (
    .clk(clk), .rst(rst), .start_beat(start_beat), .mode_in(mode),
    .order_id_in(order_id), .side_in(side), .price_in(price),
    .quantity_in(quantity), .cmd(cmd), .sts(sts), .strobe(strobe),
    .is_trade(is_trade), .maker_id(maker_id), .taker_id(taker_id),
    .trade_price(trade_price), .trade_quantity(trade_quantity),
    .sequence_res(sequence_res), .status(status), .remaining(remaining),
    .last(last)
  );

`ifndef SYNTHESIS
  a_trade_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && is_trade |-> !last) else $error("trade beat marked last");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("busy after final beat");
  a_no_beat_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("beat while idle");
`endif

endmodule
